// ----- src/i2p_pkg.sv -----
// Shared types, constants and helper functions of the infix-to-postfix converter.
`default_nettype none

package i2p_pkg;

  // Operator stack geometry. The top entry is held in its own register, the
  // entries beneath it in a small array.
  localparam int unsigned STACK_DEPTH = 16;
  localparam int unsigned CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int unsigned LOWER_DEPTH = STACK_DEPTH - 1;
  localparam int unsigned IDX_W       = (LOWER_DEPTH > 1) ? $clog2(LOWER_DEPTH) : 1;

  localparam logic [7:0] CH_OPEN   = 8'h28;
  localparam logic [7:0] CH_CLOSE  = 8'h29;
  localparam logic [7:0] CH_TIMES  = 8'h2A;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DIVIDE = 8'h2F;

  typedef enum logic [2:0] {
    OP_OPEN   = 3'd0,
    OP_PLUS   = 3'd1,
    OP_MINUS  = 3'd2,
    OP_TIMES  = 3'd3,
    OP_DIVIDE = 3'd4
  } opcode_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_OVERFLOW = 2'd1,
    ERR_CLOSE    = 2'd2,
    ERR_OPEN     = 2'd3
  } err_e;

  typedef enum logic [2:0] {
    CLS_OPERAND,
    CLS_OPEN,
    CLS_CLOSE,
    CLS_OPER,
    CLS_END
  } class_e;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_POP_EMIT,
    ACT_POP_DROP,
    ACT_PUSH,
    ACT_EMIT_SYM,
    ACT_EMIT_FLAG
  } act_e;

  typedef enum logic {
    ST_IDLE,
    ST_BUSY
  } state_e;

  typedef struct packed {
    logic    load;
    logic    step;
    act_e    act;
    logic    last;
    logic    done;
    err_e    err;
    logic    mark_open;
  } i2p_cmd_t;

  typedef struct packed {
    class_e  cls;
    opcode_e op;
    logic    cnt_zero;
    logic    cnt_full;
    opcode_e top;
    logic    next_valid;
    opcode_e next;
    logic    open_seen;
    logic    out_free;
  } i2p_status_t;

  function automatic logic [1:0] level_of(opcode_e code);
    logic [1:0] lv;
    unique case (code)
      OP_TIMES, OP_DIVIDE: lv = 2'd2;
      OP_PLUS, OP_MINUS:   lv = 2'd1;
      default:             lv = 2'd0;
    endcase
    return lv;
  endfunction

  function automatic logic [7:0] char_of(opcode_e code);
    logic [7:0] ch;
    unique case (code)
      OP_OPEN:   ch = CH_OPEN;
      OP_PLUS:   ch = CH_PLUS;
      OP_MINUS:  ch = CH_MINUS;
      OP_TIMES:  ch = CH_TIMES;
      OP_DIVIDE: ch = CH_DIVIDE;
      default:   ch = 8'd0;
    endcase
    return ch;
  endfunction

  function automatic class_e classify(logic [7:0] sym, logic is_end);
    class_e cls;
    if (is_end) begin
      cls = CLS_END;
    end else if (sym == CH_OPEN) begin
      cls = CLS_OPEN;
    end else if (sym == CH_CLOSE) begin
      cls = CLS_CLOSE;
    end else if (sym == CH_PLUS || sym == CH_MINUS || sym == CH_TIMES ||
                 sym == CH_DIVIDE) begin
      cls = CLS_OPER;
    end else begin
      cls = CLS_OPERAND;
    end
    return cls;
  endfunction

  // Stack code of a character; anything that is not an operator maps to OP_OPEN.
  function automatic opcode_e code_of(logic [7:0] sym);
    opcode_e code;
    if (sym == CH_PLUS) begin
      code = OP_PLUS;
    end else if (sym == CH_MINUS) begin
      code = OP_MINUS;
    end else if (sym == CH_TIMES) begin
      code = OP_TIMES;
    end else if (sym == CH_DIVIDE) begin
      code = OP_DIVIDE;
    end else begin
      code = OP_OPEN;
    end
    return code;
  endfunction

endpackage

`default_nettype wire

// ----- src/i2p_ctrl.sv -----
// Controller of the infix-to-postfix converter: item sequencing and step decisions.
`default_nettype none

module i2p_ctrl
  import i2p_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire i2p_status_t status_i,
  output i2p_cmd_t         cmd_o
);

  state_e state_q, state_d;
  logic   fin;
  logic   emits;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = ST_BUSY;
        end
      end
      ST_BUSY: begin
        if (cmd_o.step && fin) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // One step per cycle, unless a step with a result waits for the output. For an
  // operator or ')', the last flag of a popped character is decided by looking one entry below the top of the stack.
  always_comb begin
    cmd_o.load      = 1'b0;
    cmd_o.step      = 1'b0;
    cmd_o.act       = ACT_NONE;
    cmd_o.last      = 1'b0;
    cmd_o.done      = 1'b0;
    cmd_o.err       = ERR_NONE;
    cmd_o.mark_open = 1'b0;
    fin             = 1'b0;
    emits           = 1'b0;
    in_ready_o      = (state_q == ST_IDLE);
    cmd_o.load      = (state_q == ST_IDLE) && in_valid_i;
    if (state_q == ST_BUSY) begin
      unique case (status_i.cls)
        CLS_OPERAND: begin
          cmd_o.act  = ACT_EMIT_SYM;
          cmd_o.last = 1'b1;
          fin        = 1'b1;
        end
        CLS_OPEN: begin
          fin = 1'b1;
          if (status_i.cnt_full) begin
            cmd_o.act  = ACT_EMIT_FLAG;
            cmd_o.err  = ERR_OVERFLOW;
            cmd_o.last = 1'b1;
          end else begin
            cmd_o.act = ACT_PUSH;
          end
        end
        CLS_OPER: begin
          if (!status_i.cnt_zero &&
              level_of(status_i.top) >= level_of(status_i.op)) begin
            cmd_o.act  = ACT_POP_EMIT;
            cmd_o.last = !(status_i.next_valid &&
                           level_of(status_i.next) >= level_of(status_i.op));
          end else if (status_i.cnt_full) begin
            cmd_o.act  = ACT_EMIT_FLAG;
            cmd_o.err  = ERR_OVERFLOW;
            cmd_o.last = 1'b1;
            fin        = 1'b1;
          end else begin
            cmd_o.act = ACT_PUSH;
            fin       = 1'b1;
          end
        end
        CLS_CLOSE: begin
          if (status_i.cnt_zero) begin
            cmd_o.act  = ACT_EMIT_FLAG;
            cmd_o.err  = ERR_CLOSE;
            cmd_o.last = 1'b1;
            fin        = 1'b1;
          end else if (status_i.top == OP_OPEN) begin
            cmd_o.act = ACT_POP_DROP;
            fin       = 1'b1;
          end else begin
            cmd_o.act  = ACT_POP_EMIT;
            cmd_o.last = status_i.next_valid && (status_i.next == OP_OPEN);
          end
        end
        CLS_END: begin
          if (status_i.cnt_zero) begin
            cmd_o.act  = ACT_EMIT_FLAG;
            cmd_o.done = 1'b1;
            cmd_o.err  = status_i.open_seen ? ERR_OPEN : ERR_NONE;
            cmd_o.last = 1'b1;
            fin        = 1'b1;
          end else if (status_i.top == OP_OPEN) begin
            cmd_o.act       = ACT_POP_DROP;
            cmd_o.mark_open = 1'b1;
          end else begin
            cmd_o.act = ACT_POP_EMIT;
          end
        end
        default: begin
          cmd_o.act = ACT_NONE;
          fin       = 1'b1;
        end
      endcase
      emits      = (cmd_o.act == ACT_POP_EMIT) || (cmd_o.act == ACT_EMIT_SYM) ||
                   (cmd_o.act == ACT_EMIT_FLAG);
      cmd_o.step = !emits || status_i.out_free;
    end
  end

endmodule

`default_nettype wire

// ----- src/i2p_dpath.sv -----
// Datapath of the infix-to-postfix converter: item register, operator stack, result register.
`default_nettype none

module i2p_dpath
  import i2p_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic [7:0]  in_symbol_i,
  input  wire logic        in_end_i,
  input  wire i2p_cmd_t    cmd_i,
  output i2p_status_t      status_o,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic [7:0]       out_char_o,
  output logic             out_char_valid_o,
  output logic             out_last_o,
  output logic             out_done_o,
  output logic [1:0]       out_err_o
);

  logic [7:0]       sym_q;
  class_e           cls_q;
  opcode_e          op_q;
  logic [CNT_W-1:0] count_q, count_d;
  opcode_e          top_q, top_d;
  opcode_e          lower_q [LOWER_DEPTH];
  logic             open_seen_q, open_seen_d;
  logic             out_valid_q, out_valid_d;
  logic [7:0]       out_char_q;
  logic             char_valid_q;
  logic             last_q;
  logic             done_q;
  err_e             err_q;

  logic [CNT_W-1:0] cnt_m1;
  logic [CNT_W-1:0] cnt_m2;
  logic [IDX_W-1:0] push_idx;
  logic [IDX_W-1:0] next_idx;
  opcode_e          next_code;
  logic             next_valid;
  logic             out_free;
  logic             emit;
  logic             do_push;

  assign cnt_m1     = count_q - CNT_W'(1);
  assign cnt_m2     = count_q - CNT_W'(2);
  assign push_idx   = cnt_m1[IDX_W-1:0];
  assign next_idx   = cnt_m2[IDX_W-1:0];
  assign next_valid = (count_q >= CNT_W'(2));
  assign next_code  = next_valid ? lower_q[next_idx] : OP_OPEN;
  assign out_free   = !out_valid_q || out_ready_i;
  assign emit       = cmd_i.step && ((cmd_i.act == ACT_POP_EMIT) ||
                      (cmd_i.act == ACT_EMIT_SYM) || (cmd_i.act == ACT_EMIT_FLAG));
  assign do_push    = cmd_i.step && (cmd_i.act == ACT_PUSH);

  always_comb begin
    status_o.cls        = cls_q;
    status_o.op         = op_q;
    status_o.cnt_zero   = (count_q == '0);
    status_o.cnt_full   = (count_q >= CNT_W'(STACK_DEPTH));
    status_o.top        = top_q;
    status_o.next_valid = next_valid;
    status_o.next       = next_code;
    status_o.open_seen  = open_seen_q;
    status_o.out_free   = out_free;
  end

  always_comb begin
    count_d     = count_q;
    top_d       = top_q;
    open_seen_d = open_seen_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (emit) begin
      out_valid_d = 1'b1;
    end
    if (cmd_i.load) begin
      open_seen_d = 1'b0;
    end
    if (cmd_i.step) begin
      unique case (cmd_i.act)
        ACT_POP_EMIT, ACT_POP_DROP: begin
          count_d = cnt_m1;
          top_d   = next_code;
        end
        ACT_PUSH: begin
          count_d = count_q + CNT_W'(1);
          top_d   = op_q;
        end
        default: begin
          count_d = count_q;
        end
      endcase
      if (cmd_i.mark_open) begin
        open_seen_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      top_q       <= OP_OPEN;
      open_seen_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      count_q     <= count_d;
      top_q       <= top_d;
      open_seen_q <= open_seen_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload and stack storage carry no reset; only entries below the count
  // are ever read.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sym_q <= in_symbol_i;
      cls_q <= classify(in_symbol_i, in_end_i);
      op_q  <= code_of(in_symbol_i);
    end
    if (do_push && (count_q != '0)) begin
      lower_q[push_idx] <= top_q;
    end
    if (emit) begin
      unique case (cmd_i.act)
        ACT_EMIT_SYM:  out_char_q <= sym_q;
        ACT_POP_EMIT:  out_char_q <= char_of(top_q);
        default:       out_char_q <= 8'd0;
      endcase
      char_valid_q <= (cmd_i.act != ACT_EMIT_FLAG);
      last_q       <= cmd_i.last;
      done_q       <= cmd_i.done;
      err_q        <= cmd_i.err;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign out_char_o       = out_char_q;
  assign out_char_valid_o = char_valid_q;
  assign out_last_o       = last_q;
  assign out_done_o       = done_q;
  assign out_err_o        = err_q;

endmodule

`default_nettype wire

// ----- src/infix_to_postfix_converter_top.sv -----
// Top level of the infix-to-postfix converter (shunting-yard with a bounded stack).
//
// Input stream: one infix character per transaction in s_axis_tdata_i; a
// transaction with s_axis_tlast_i set ends the expression, flushes the
// operator stack and produces a closing result with tuser expression_done.
// Output stream: one postfix character, error item or closing item per
// transaction; m_axis_tlast_o marks the final result caused by an input.
// Sequence: an input transaction is taken into the item register, then the
// controller does one step per cycle while no result step is stalled: one
// step for an operand, '(' or plain push, one more step for every operator
// popped or '(' discarded. The stack is walked one entry per step.
// Each result is registered in an output register by its step, and s_axis
// is taken again as soon as the last step of the item has been done;
// until then no new input is accepted.
// Reset empties the stack and the output register. When the receiver stalls,
// any step that would produce a result waits; steps without a result go on.
`default_nettype none

module infix_to_postfix_converter_top
  import i2p_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] symbol
  input  wire logic       s_axis_tlast_i,   // end_marker
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,   // [7:0] out_char
  output logic            m_axis_tlast_o,   // last_of_run
  output logic [3:0]      m_axis_tuser_o    // [0] char_valid, [1] expression_done,
                                            // [3:2] error_code
);

  i2p_cmd_t    cmd;
  i2p_status_t status;
  logic        char_valid;
  logic        done;
  logic [1:0]  err;

  i2p_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  i2p_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_symbol_i      (s_axis_tdata_i),
    .in_end_i         (s_axis_tlast_i),
    .cmd_i            (cmd),
    .status_o         (status),
    .out_valid_o      (m_axis_tvalid_o),
    .out_ready_i      (m_axis_tready_i),
    .out_char_o       (m_axis_tdata_o),
    .out_char_valid_o (char_valid),
    .out_last_o       (m_axis_tlast_o),
    .out_done_o       (done),
    .out_err_o        (err)
  );

  assign m_axis_tuser_o = {err, done, char_valid};

endmodule

`default_nettype wire
